### design/rau_pkg.sv
// Package: shared constants, and op and status codes
`timescale 1ns / 1ps
package rau_pkg;
   localparam int DefWidth = 16;
   localparam int OpWidth  = 3;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_NEG  = 3'd4,
      OP_NORM = 3'd5,
      OP_CMP  = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADDEN = 2'd1,
      ST_DIVZ   = 2'd2,
      ST_OVF    = 2'd3
   } status_type;
endpackage

### design/rau_if.sv
// Interface: valid/ready channel with a generic payload
`timescale 1ns / 1ps
interface rau_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/rau_front.sv
// Front: accepts items, classifies, checks denominators, forms the exact cross products
`timescale 1ns / 1ps
module rau_front #(
   parameter int WIDTH = rau_pkg::DefWidth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_op,
   input  logic [WIDTH-1:0]     req_a_num,
   input  logic [WIDTH-1:0]     req_a_den,
   input  logic [WIDTH-1:0]     req_b_num,
   input  logic [WIDTH-1:0]     req_b_den,
   output logic                 q_valid,
   input  logic                 q_ready,
   output logic [2:0]           q_op,
   output logic [1:0]           q_status,
   output logic                 q_neg,
   output logic [2*WIDTH:0]     q_num,
   output logic [2*WIDTH-1:0]   q_den
);
   import rau_pkg::*;

   localparam int PW = 2 * WIDTH;

   logic              st_valid_ff, st_valid_in;
   logic [2:0]        st_op_ff, st_op_in;
   logic [1:0]        st_status_ff, st_status_in;
   logic              an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [WIDTH-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic              an_s_in, ad_s_in, bn_s_in, bd_s_in;
   logic [WIDTH-1:0]  an_in, ad_in, bn_in, bd_in;
   logic              q_valid_ff, q_valid_in;
   logic [2:0]        q_op_ff, q_op_in;
   logic [1:0]        q_status_ff, q_status_in;
   logic              q_neg_ff, q_neg_in;
   logic [PW:0]       q_num_ff, q_num_in;
   logic [PW-1:0]     q_den_ff, q_den_in;
   logic              st_adv, q_take;
   logic [PW-1:0]     p1, p2, pd, pbn;
   logic              s1, s2, sa, sb;

   function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign q_take    = !q_valid_ff || q_ready;
   assign st_adv    = st_valid_ff && q_take;
   assign req_ready = !st_valid_ff || st_adv;

   always_comb begin
      st_valid_in  = st_valid_ff;
      st_op_in     = st_op_ff;
      st_status_in = st_status_ff;
      {an_s_in, ad_s_in, bn_s_in, bd_s_in} = {an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff};
      {an_in, ad_in, bn_in, bd_in} = {an_ff, ad_ff, bn_ff, bd_ff};
      if (st_adv) begin
         st_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         st_valid_in = 1'b1;
         st_op_in    = req_op;
         an_s_in = req_a_num[WIDTH-1];
         ad_s_in = req_a_den[WIDTH-1];
         bn_s_in = req_b_num[WIDTH-1];
         bd_s_in = req_b_den[WIDTH-1];
         an_in = mag(req_a_num);
         ad_in = mag(req_a_den);
         bn_in = mag(req_b_num);
         bd_in = mag(req_b_den);
         if (op_type'(req_op) == OP_NONE) begin
            st_status_in = ST_OK;
         end else if (req_a_den == '0 || (op_type'(req_op) != OP_NEG
               && op_type'(req_op) != OP_NORM && req_b_den == '0)) begin
            st_status_in = ST_BADDEN;
         end else if (op_type'(req_op) == OP_DIV && req_b_num == '0) begin
            st_status_in = ST_DIVZ;
         end else begin
            st_status_in = ST_OK;
         end
      end
   end

   // magnitudes are WIDTH bits wide so that -2^(WIDTH-1) keeps its full magnitude
   assign sa  = an_s_ff ^ ad_s_ff;
   assign sb  = bn_s_ff ^ bd_s_ff;
   assign p1  = PW'(an_ff) * PW'(bd_ff);
   assign p2  = PW'(bn_ff) * PW'(ad_ff);
   assign pd  = PW'(ad_ff) * PW'(bd_ff);
   assign pbn = PW'(an_ff) * PW'(bn_ff);
   assign s1  = sa;
   assign s2  = (op_type'(st_op_ff) == OP_ADD) ? sb : !sb;

   always_comb begin
      q_valid_in  = q_valid_ff;
      q_op_in     = q_op_ff;
      q_status_in = q_status_ff;
      q_neg_in    = q_neg_ff;
      q_num_in    = q_num_ff;
      q_den_in    = q_den_ff;
      if (q_valid_ff && q_ready) begin
         q_valid_in = 1'b0;
      end
      if (st_adv) begin
         q_valid_in  = 1'b1;
         q_op_in     = st_op_ff;
         q_status_in = st_status_ff;
         q_den_in    = pd;
         q_neg_in    = 1'b0;
         q_num_in    = '0;
         unique case (op_type'(st_op_ff))
            OP_ADD, OP_SUB, OP_CMP: begin
               if (s1 == s2) begin
                  q_neg_in = s1;
                  q_num_in = {1'b0, p1} + {1'b0, p2};
               end else if (p1 >= p2) begin
                  q_neg_in = s1;
                  q_num_in = {1'b0, p1 - p2};
               end else begin
                  q_neg_in = s2;
                  q_num_in = {1'b0, p2 - p1};
               end
            end
            OP_MUL: begin
               q_neg_in = sa ^ sb;
               q_num_in = {1'b0, pbn};
            end
            OP_DIV: begin
               q_neg_in = sa ^ sb;
               q_num_in = {1'b0, p1};
               q_den_in = p2;
            end
            OP_NEG, OP_NORM: begin
               q_neg_in = (op_type'(st_op_ff) == OP_NEG) ? !sa : sa;
               q_num_in = (PW + 1)'(an_ff);
               q_den_in = PW'(ad_ff);
            end
            default: begin
               q_num_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         q_valid_ff  <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
         q_valid_ff  <= q_valid_in;
      end
      st_op_ff     <= st_op_in;
      st_status_ff <= st_status_in;
      {an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff} <= {an_s_in, ad_s_in, bn_s_in, bd_s_in};
      {an_ff, ad_ff, bn_ff, bd_ff} <= {an_in, ad_in, bn_in, bd_in};
      q_op_ff     <= q_op_in;
      q_status_ff <= q_status_in;
      q_neg_ff    <= q_neg_in;
      q_num_ff    <= q_num_in;
      q_den_ff    <= q_den_in;
   end

   assign q_valid  = q_valid_ff;
   assign q_op     = q_op_ff;
   assign q_status = q_status_ff;
   assign q_neg    = q_neg_ff;
   assign q_num    = q_num_ff;
   assign q_den    = q_den_ff;

`ifndef NO_ASSERTIONS
   a_q_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_num) && $stable(q_den))
      else $error("queued item changed while stalled");
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_status == ST_OK && q_op != OP_NONE |-> q_den != '0)
      else $error("zero denominator passed the check");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !st_valid_ff |-> req_ready)
      else $error("empty stage not ready");
`endif
endmodule

### design/rau_back.sv
// Back: binary gcd reduction, range check and result formatting
`timescale 1ns / 1ps
module rau_back #(
   parameter int WIDTH = rau_pkg::DefWidth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  logic [2:0]           q_op,
   input  logic [1:0]           q_status,
   input  logic                 q_neg,
   input  logic [2*WIDTH:0]     q_num,
   input  logic [2*WIDTH-1:0]   q_den,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WIDTH-1:0]     rsp_res_num,
   output logic [WIDTH-2:0]     rsp_res_den,
   output logic                 rsp_less,
   output logic                 rsp_equal,
   output logic                 rsp_greater,
   output logic [1:0]           rsp_status
);
   import rau_pkg::*;

   localparam int PW = 2 * WIDTH + 1;
   localparam int SW = $clog2(PW + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_GCD   = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     n_ff, n_in, d_ff, d_in, x_ff, x_in, y_ff, y_in;
   logic [PW-1:0]     dif_d_ff, dif_d_in;
   logic [SW-1:0]     k_ff, k_in;
   logic              neg_ff, neg_in;
   logic [2:0]        op_ff, op_in;
   logic [1:0]        st_ff, st_in;
   logic              o_valid_ff, o_valid_in;
   logic [WIDTH-1:0]  o_num_ff, o_num_in;
   logic [WIDTH-2:0]  o_den_ff, o_den_in;
   logic [2:0]        o_flags_ff, o_flags_in;
   logic [1:0]        o_st_ff, o_st_in;
   logic [PW-1:0]     g, qn, qd, half;
   logic [PW-1:0]     dif;
   logic              busy_done;

   // common powers of two are shifted out during the search; the odd part of the gcd ends in y
   assign half = PW'(1) << (WIDTH - 1);
   assign g    = y_ff;
   assign dif  = (x_ff > y_ff) ? x_ff - y_ff : y_ff - x_ff;

   assign q_ready   = (state_ff == S_IDLE);
   assign busy_done = !o_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      n_in = n_ff; d_in = d_ff; x_in = x_ff; y_in = y_ff; k_in = k_ff;
      dif_d_in = dif_d_ff;
      neg_in = neg_ff; op_in = op_ff; st_in = st_ff;
      o_valid_in = o_valid_ff; o_num_in = o_num_ff; o_den_in = o_den_ff;
      o_flags_in = o_flags_ff; o_st_in = o_st_ff;
      qn = '0;
      qd = '0;
      if (o_valid_ff && rsp_ready) begin
         o_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               n_in   = q_num;
               d_in   = PW'(q_den);
               x_in   = q_num;
               y_in   = PW'(q_den);
               k_in   = '0;
               neg_in = q_neg;
               op_in  = q_op;
               st_in  = q_status;
               if (q_status != ST_OK || op_type'(q_op) == OP_NONE
                     || op_type'(q_op) == OP_CMP || q_num == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            // binary gcd, one step a cycle
            if (x_ff[0] == 1'b0 && y_ff[0] == 1'b0) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               n_in = n_ff >> 1;
               d_in = d_ff >> 1;
            end else if (x_ff[0] == 1'b0) begin
               x_in = x_ff >> 1;
            end else if (y_ff[0] == 1'b0) begin
               y_in = y_ff >> 1;
            end else if (x_ff == y_ff) begin
               state_in = (y_ff == PW'(1)) ? S_DONE : S_SHIFT;
               x_in = '0;
               y_in = y_ff;
               k_in = '0;
               dif_d_in = '0;
            end else begin
               x_in = (x_ff > y_ff) ? dif >> 1 : x_ff;
               y_in = (x_ff > y_ff) ? y_ff : dif >> 1;
            end
         end
         S_SHIFT: begin
            // odd divisor g: restoring division of n and d, one quotient bit a cycle
            qn = {n_ff[PW-2:0], 1'b0};
            qd = {d_ff[PW-2:0], 1'b0};
            if ({x_ff[PW-2:0], n_ff[PW-1]} >= g) begin
               x_in = {x_ff[PW-2:0], n_ff[PW-1]} - g;
               qn[0] = 1'b1;
            end else begin
               x_in = {x_ff[PW-2:0], n_ff[PW-1]};
            end
            n_in = qn;
            // denominator remainder kept in a dedicated register slice
            d_in = qd;
            if ({dif_d_ff[PW-2:0], d_ff[PW-1]} >= g) begin
               dif_d_in = {dif_d_ff[PW-2:0], d_ff[PW-1]} - g;
               d_in[0] = 1'b1;
            end else begin
               dif_d_in = {dif_d_ff[PW-2:0], d_ff[PW-1]};
            end
            k_in = k_ff + 1'b1;
            if (k_ff == SW'(PW - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (busy_done) begin
               o_valid_in = 1'b1;
               o_num_in   = '0;
               o_den_in   = (WIDTH-1)'(1);
               o_flags_in = '0;
               o_st_in    = st_ff;
               if (st_ff == ST_OK && op_type'(op_ff) == OP_CMP) begin
                  if (n_ff == '0) begin
                     o_flags_in = 3'b010;
                  end else if (neg_ff) begin
                     o_flags_in = 3'b100;
                  end else begin
                     o_flags_in = 3'b001;
                  end
               end else if (st_ff == ST_OK && op_type'(op_ff) != OP_NONE
                     && n_ff != '0) begin
                  if (d_ff > half - 1'b1 || (neg_ff ? n_ff > half : n_ff > half - 1'b1)) begin
                     o_st_in = ST_OVF;
                  end else begin
                     o_num_in = neg_ff ? WIDTH'(~n_ff + 1'b1) : WIDTH'(n_ff);
                     o_den_in = (WIDTH-1)'(d_ff);
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
      end
      n_ff <= n_in; d_ff <= d_in; x_ff <= x_in; y_ff <= y_in; k_ff <= k_in;
      dif_d_ff <= dif_d_in;
      neg_ff <= neg_in; op_ff <= op_in; st_ff <= st_in;
      o_num_ff <= o_num_in; o_den_ff <= o_den_in;
      o_flags_ff <= o_flags_in; o_st_ff <= o_st_in;
   end

   assign rsp_valid   = o_valid_ff;
   assign rsp_res_num = o_num_ff;
   assign rsp_res_den = o_den_ff;
   assign rsp_less    = o_flags_ff[2];
   assign rsp_equal   = o_flags_ff[1];
   assign rsp_greater = o_flags_ff[0];
   assign rsp_status  = o_st_ff;

`ifndef NO_ASSERTIONS
   a_onehot_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_less, rsp_equal, rsp_greater}))
      else $error("more than one compare flag");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != '0)
      else $error("zero result denominator");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_res_num == '0)
      else $error("error result not cleared");
`endif
endmodule

### design/rational_arithmetic_unit.sv
// Top level: rational arithmetic unit with gcd reduction
`timescale 1ns / 1ps
// Exact add, subtract, multiply, divide, negate, normalize and compare on two
// WIDTH-bit fractions. Results are reduced and carry a positive denominator.
// The front stage registers each item, then forms the exact cross products into
// its queue register; the back stage reduces by a binary gcd (one step a cycle) and
// then divides both terms by the odd gcd, one quotient bit a cycle. Errors,
// compares, no-ops and zero results skip the reduction. The front accepts new
// items while the back is busy, holding up to two in its stage and queue registers.
module rational_arithmetic_unit #(
   parameter int WIDTH = rau_pkg::DefWidth
) (
   input  logic  clock,
   input  logic  reset,
   rau_if.sink   req,
   rau_if.source rsp
);
   import rau_pkg::*;

   logic               q_valid, q_ready, q_neg;
   logic [2:0]         q_op;
   logic [1:0]         q_status;
   logic [2*WIDTH:0]   q_num;
   logic [2*WIDTH-1:0] q_den;

   rau_front #(.WIDTH(WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_op    (req.data.op),
      .req_a_num (req.data.a_num),
      .req_a_den (req.data.a_den),
      .req_b_num (req.data.b_num),
      .req_b_den (req.data.b_den),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_op      (q_op),
      .q_status  (q_status),
      .q_neg     (q_neg),
      .q_num     (q_num),
      .q_den     (q_den)
   );

   rau_back #(.WIDTH(WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_op        (q_op),
      .q_status    (q_status),
      .q_neg       (q_neg),
      .q_num       (q_num),
      .q_den       (q_den),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_res_num (rsp.data.res_num),
      .rsp_res_den (rsp.data.res_den),
      .rsp_less    (rsp.data.less),
      .rsp_equal   (rsp.data.equal),
      .rsp_greater (rsp.data.greater),
      .rsp_status  (rsp.data.status)
   );
endmodule

### dv/rau_tb_types.sv
// Package: item structs for the request and response channels of the testbench
`timescale 1ns / 1ps
package rau_tb_types;
   import rau_pkg::*;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] a_num;
      logic signed [15:0] a_den;
      logic signed [15:0] b_num;
      logic signed [15:0] b_den;
   } req_item_t;

   typedef struct packed {
      logic signed [15:0] res_num;
      logic [14:0]        res_den;
      logic               less;
      logic               equal;
      logic               greater;
      logic [1:0]         status;
   } rsp_item_t;
endpackage

### dv/tb_rational_arithmetic_unit.sv
// Testbench: random and directed fraction operations checked against an exact predictor
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
   import rau_pkg::*;
   import rau_tb_types::*;

   localparam int StallLimit = 3000;
   localparam longint Half = 64'd32768;

   logic clock;
   logic reset;

   rau_if #(.payload_type(req_item_t)) req_ch ();
   rau_if #(.payload_type(rsp_item_t)) rsp_ch ();

   rational_arithmetic_unit #(.WIDTH(16)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   req_item_t pending_q[$];
   rsp_item_t expected_q[$];
   int        errors;
   bit        quiet;
   int        send_gap;
   int        recv_gap;
   int        hold_left;
   bit        hold_done;
   int        rsp_count;
   int        idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint magnitude(logic signed [15:0] v);
      return (v < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint gcd64(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // reduce, sign-normalize and range-check one fraction
   function automatic void reduce_frac(bit neg, longint n, longint d, ref rsp_item_t r);
      longint g;
      g = gcd64(n, d);
      if (g != 0) begin
         n = n / g;
         d = d / g;
      end
      if (n == 0) begin
         neg = 0;
         d = 1;
      end
      if (d > Half - 1 || (neg ? n > Half : n > Half - 1)) begin
         r.status = ST_OVF;
         return;
      end
      r.res_num = neg ? 16'(-n) : 16'(n);
      r.res_den = 15'(d);
   endfunction

   function automatic rsp_item_t predict_fraction_op(req_item_t it);
      rsp_item_t r;
      bit        an, bn, bs, s;
      longint    am, ad, bm, bd, x, y, m;
      r = '0;
      r.res_den = 15'd1;
      r.status = ST_OK;
      am = magnitude(it.a_num);
      ad = magnitude(it.a_den);
      bm = magnitude(it.b_num);
      bd = magnitude(it.b_den);
      an = (it.a_num < 0) != (it.a_den < 0);
      bn = (it.b_num < 0) != (it.b_den < 0);
      if (it.op == OP_NONE) return r;
      if (ad == 0 || (it.op != OP_NEG && it.op != OP_NORM && bd == 0)) begin
         r.status = ST_BADDEN;
         return r;
      end
      case (it.op)
         OP_ADD, OP_SUB, OP_CMP: begin
            bs = (it.op == OP_ADD) ? bn : !bn;
            x = am * bd;
            y = bm * ad;
            if (an == bs) begin
               s = an;
               m = x + y;
            end else if (x >= y) begin
               s = an;
               m = x - y;
            end else begin
               s = bs;
               m = y - x;
            end
            if (it.op == OP_CMP) begin
               if (m == 0) r.equal = 1;
               else if (s) r.less = 1;
               else r.greater = 1;
            end else begin
               reduce_frac(s, m, ad * bd, r);
            end
         end
         OP_MUL: reduce_frac(an != bn, am * bm, ad * bd, r);
         OP_DIV: begin
            if (bm == 0) r.status = ST_DIVZ;
            else reduce_frac(an != bn, am * bd, ad * bm, r);
         end
         OP_NEG: reduce_frac(!an, am, ad, r);
         default: reduce_frac(an, am, ad, r);
      endcase
      if (r.status != ST_OK) begin
         r.res_num = '0;
         r.res_den = 15'd1;
         r.less = 0;
         r.equal = 0;
         r.greater = 0;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom);
         2, 3: return 16'(int'($urandom_range(0, 40)) - 20);
         4: return 16'(int'($urandom_range(0, 600)) - 300);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               3: return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
      endcase
   endfunction

   task automatic add_item(op_type op, int an, int ad, int bn, int bd);
      req_item_t it;
      it.op = op;
      it.a_num = 16'(an);
      it.a_den = 16'(ad);
      it.b_num = 16'(bn);
      it.b_den = 16'(bd);
      pending_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_ch.valid || expected_q.size() > 0)
         @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(predict_fraction_op(req_ch.data));
         if (req_ch.valid && !req_ch.ready) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 2);
            req_ch.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_q.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver, checker and watchdog
   always @(posedge clock) begin
      rsp_item_t exp_r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
         hold_done <= 0;
         rsp_count <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, StallLimit);
            $display("Mismatches found");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected item %p", $time, rsp_ch.data);
               errors = errors + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_ch.data.res_num !== exp_r.res_num
                   || rsp_ch.data.res_den !== exp_r.res_den
                   || rsp_ch.data.less !== exp_r.less
                   || rsp_ch.data.equal !== exp_r.equal
                   || rsp_ch.data.greater !== exp_r.greater
                   || rsp_ch.data.status !== exp_r.status) begin
                  $display("%0t: expected %p actual %p", $time, exp_r, rsp_ch.data);
                  errors = errors + 1;
               end
            end
         end
         if (!hold_done && rsp_count == 300) begin
            hold_done <= 1;
            hold_left <= 400;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_item_t it;
      errors = 0;
      quiet = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_item(OP_ADD, 1, 2, 1, 3);
      add_item(OP_SUB, 1, 2, 1, 2);
      add_item(OP_MUL, 32767, 1, 32767, 1);
      add_item(OP_MUL, 1, 200, 1, 200);
      add_item(OP_DIV, 3, 4, -6, 8);
      add_item(OP_DIV, 3, 4, 0, 5);
      add_item(OP_DIV, 3, 0, 0, 5);
      add_item(OP_NEG, -32768, 1, 0, 0);
      add_item(OP_NEG, 32767, -1, 0, 0);
      add_item(OP_NORM, -32768, -1, 0, 0);
      add_item(OP_NORM, 6, -4, 0, 0);
      add_item(OP_NORM, 5, 0, 1, 1);
      add_item(OP_NORM, 0, -7, 1, 1);
      add_item(OP_ADD, 1, 1, 2, 0);
      add_item(OP_CMP, 1, 3, 2, 6);
      add_item(OP_CMP, -1, 3, 1, 3);
      add_item(OP_CMP, 5, -3, -7, 3);
      add_item(OP_CMP, 1, 0, 1, 1);
      add_item(OP_NONE, 1, 0, 1, 0);
      add_item(OP_SUB, -32768, 1, 32767, 1);
      add_item(OP_ADD, 32767, 32767, -32768, -32768);
      add_item(OP_MUL, -32768, 32767, 32767, -32768);
      wait_drained();

      for (int i = 0; i < 1600; i++) begin
         it.op = op_type'($urandom_range(0, 7));
         it.a_num = pick_value();
         it.a_den = pick_value();
         it.b_num = pick_value();
         it.b_den = pick_value();
         pending_q.push_back(it);
         if (i == 800) begin
            // stimulus generation pauses until every queued item has been sent and answered
            wait_drained();
         end
      end
      // no idling for the last stretch of items
      while (pending_q.size() > 200)
         @(posedge clock);
      quiet = 1;
      wait_drained();
      repeat (200) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

### filelist.f
design/rau_pkg.sv
design/rau_if.sv
design/rau_front.sv
design/rau_back.sv
design/rational_arithmetic_unit.sv
dv/rau_tb_types.sv
dv/tb_rational_arithmetic_unit.sv
